[hdl/dhb_pkg.sv]
// Package: shared types and constants of the deadband/heartbeat publish decision unit.
package dhb_pkg;

	localparam int POINT_COUNT = 256;
	localparam int IDX_W = 8;
	localparam int VALUE_W = 32;
	localparam int TICK_W = 32;
	localparam int BAND_W = 16;
	localparam int HB_W = 16;
	localparam int MS_W = 10;
	localparam int HB_MS_W = HB_W + MS_W;
	localparam logic [MS_W-1:0] MS_PER_SECOND = MS_W'(1000);
	localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(POINT_COUNT);

	typedef enum logic {
		OP_EVALUATE = 1'b0,
		OP_CLEAR    = 1'b1
	} op_t;

	typedef logic [IDX_W-1:0] point_idx_t;

	typedef struct packed {
		op_t                        operation;
		point_idx_t                 point_index;
		logic signed [VALUE_W-1:0]  sample_value;
		logic                       is_text;
		logic [BAND_W-1:0]          deadband;
		logic [HB_W-1:0]            heartbeat_seconds;
		logic [TICK_W-1:0]          now_ms;
	} eval_item_t;

	typedef struct packed {
		logic                       publish;
		logic signed [VALUE_W-1:0]  published_value;
	} result_t;

	// Last published value and tick of one point.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [TICK_W-1:0]  tick;
	} slot_t;

endpackage

[hdl/dhb_eval_if.sv]
// Interface: valid/ready channel carrying evaluate and clear beats.
interface dhb_eval_if;
	logic                valid;
	logic                ready;
	dhb_pkg::eval_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/dhb_result_if.sv]
// Interface: valid/ready channel carrying publish decisions.
interface dhb_result_if;
	logic             valid;
	logic             ready;
	dhb_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/dhb_slot_mem.sv]
// Module: per-point store of last published value and tick, registered read.
module dhb_slot_mem (
	input  logic                clk,
	input  logic                rd_en,
	input  dhb_pkg::point_idx_t rd_addr,
	output dhb_pkg::slot_t      rd_data,
	input  logic                wr_en,
	input  dhb_pkg::point_idx_t wr_addr,
	input  dhb_pkg::slot_t      wr_data
);

	dhb_pkg::slot_t mem [dhb_pkg::POINT_COUNT];
	dhb_pkg::slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold the read word while the reading item waits downstream.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/dhb_decide.sv]
// Module: publish decision for one evaluate beat against its point's stored state.
module dhb_decide (
	input  dhb_pkg::eval_item_t             item,
	input  logic [dhb_pkg::HB_MS_W-1:0]     hb_ms,
	input  logic                            has_published,
	input  dhb_pkg::slot_t                  slot,
	output logic                            due
);

	logic [dhb_pkg::VALUE_W:0]  sample_ext;
	logic [dhb_pkg::VALUE_W:0]  last_ext;
	logic [dhb_pkg::VALUE_W:0]  diff_fwd;
	logic [dhb_pkg::VALUE_W:0]  diff_rev;
	logic [dhb_pkg::VALUE_W:0]  diff_abs;
	logic [dhb_pkg::TICK_W-1:0] elapsed;
	logic                       band_due;
	logic                       text_due;
	logic                       hb_due;

	// Sign-extend to 33 bits so the difference cannot overflow.
	assign sample_ext = {item.sample_value[dhb_pkg::VALUE_W-1], item.sample_value};
	assign last_ext   = {slot.value[dhb_pkg::VALUE_W-1], slot.value};
	assign diff_fwd   = sample_ext - last_ext;
	assign diff_rev   = last_ext - sample_ext;
	assign diff_abs   = diff_fwd[dhb_pkg::VALUE_W] ? diff_rev : diff_fwd;

	assign band_due = (item.deadband == '0)
		|| (diff_abs >= (dhb_pkg::VALUE_W + 1)'(item.deadband));
	assign text_due = (item.sample_value != slot.value);

	// Wrapping elapsed time against the heartbeat period.
	assign elapsed = item.now_ms - slot.tick;
	assign hb_due  = (item.heartbeat_seconds != '0)
		&& (elapsed >= dhb_pkg::TICK_W'(hb_ms));

	assign due = !has_published || (item.is_text ? text_due : band_due) || hb_due;

endmodule

[hdl/deadband_heartbeat_publish_decision_unit.sv]
// Top level: report-by-exception publish decision with deadband and heartbeat.
//
//   channel    dir  beat contents
//   eval_ch    in   operation, point_index, sample_value, is_text, deadband,
//                   heartbeat_seconds, now_ms
//   result_ch  out  publish, published_value (0 when not published)
//
// One beat per cycle sustained while results are taken; the result is registered: the
// slot memory read registers into stage 1 with the beat, the decision and the slot
// write-back close stage 1, and the result then lands in the output register.
// A write-back to the index that the next beat reads the same cycle is forwarded.
// Reset clears all published flags (flip-flops) and the control state; the slot
// memory needs no clearing, as a slot is only trusted while its flag is set.
// A stalled result register holds stage 1, and stage 1 then refuses new beats.
module deadband_heartbeat_publish_decision_unit (
	input  logic          clk,
	input  logic          arst_n,
	dhb_eval_if.sink      eval_ch,
	dhb_result_if.source  result_ch
);

	// Stage 1: accepted beat, precomputed heartbeat period, forwarding capture.
	logic                          valid_s1;
	dhb_pkg::eval_item_t           item_s1;
	logic [dhb_pkg::HB_MS_W-1:0]   hb_ms_s1;
	logic                          fwd_hit_s1;
	dhb_pkg::slot_t                fwd_slot_s1;

	// Output register.
	logic                          out_valid_q;
	dhb_pkg::result_t              out_data_q;

	// Published flags, one per point.
	logic [dhb_pkg::POINT_COUNT-1:0] flags_q;

	logic                          accept;
	logic                          advance;
	logic                          in_range;
	logic                          is_eval;
	logic                          due;
	logic                          wr_en;
	dhb_pkg::slot_t                rd_slot;
	dhb_pkg::slot_t                cur_slot;
	dhb_pkg::slot_t                wr_slot;
	logic                          flag_cur;

	// Move stage 1 on when the output register is free or being drained.
	assign advance       = valid_s1 && (!out_valid_q || result_ch.ready);
	assign eval_ch.ready = !valid_s1 || advance;
	assign accept        = eval_ch.valid && eval_ch.ready;

	assign is_eval  = (item_s1.operation == dhb_pkg::OP_EVALUATE);
	assign in_range = ({1'b0, item_s1.point_index} < dhb_pkg::IDX_LIMIT);
	assign flag_cur = flags_q[item_s1.point_index];

	// Take the previous beat's write-back when it hit this beat's slot.
	assign cur_slot = fwd_hit_s1 ? fwd_slot_s1 : rd_slot;

	assign wr_en         = advance && is_eval && in_range && due;
	assign wr_slot.value = item_s1.sample_value;
	assign wr_slot.tick  = item_s1.now_ms;

	dhb_slot_mem u_slot_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (eval_ch.data.point_index),
		.rd_data (rd_slot),
		.wr_en   (wr_en),
		.wr_addr (item_s1.point_index),
		.wr_data (wr_slot)
	);

	dhb_decide u_decide (
		.item          (item_s1),
		.hb_ms         (hb_ms_s1),
		.has_published (flag_cur),
		.slot          (cur_slot),
		.due           (due)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload; the heartbeat period is scaled to ms on the way in.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= eval_ch.data;
			hb_ms_s1    <= dhb_pkg::HB_MS_W'(eval_ch.data.heartbeat_seconds)
				* dhb_pkg::HB_MS_W'(dhb_pkg::MS_PER_SECOND);
			fwd_hit_s1  <= wr_en && (item_s1.point_index == eval_ch.data.point_index);
			fwd_slot_s1 <= wr_slot;
		end
	end

	// Clear drops every flag; a publish sets its point's flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (advance && !is_eval) begin
			flags_q <= '0;
		end else if (wr_en) begin
			flags_q[item_s1.point_index] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.publish         <= is_eval && in_range && due;
			out_data_q.published_value <= (is_eval && in_range && due)
				? item_s1.sample_value : '0;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.data  = out_data_q;

	// A clear beat leaves no point marked as published.
	a_clear_drops_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !is_eval) |=> (flags_q == '0))
		else $error("published flags not cleared after clear beat");

	// A write-back marks its point as published.
	a_publish_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> flags_q[$past(item_s1.point_index)])
		else $error("published flag not set after write-back");

	// The result's publish bit carries exactly what stage 1 decided.
	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (result_ch.valid && (result_ch.data.publish == $past(wr_en))))
		else $error("result beat does not match stage 1 decision");

	// A new beat is only taken when stage 1 is free or moving on.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && valid_s1) |-> advance)
		else $error("stage 1 overwritten while stalled");

endmodule

[tb/sv/deadband_heartbeat_publish_decision_unit_tb.sv]
// Testbench: checks publish decisions of the deadband/heartbeat unit against a local predictor.
`timescale 1ns / 100ps

module deadband_heartbeat_publish_decision_unit_tb;
	import dhb_pkg::*;

	localparam int PHASE_BEATS = 256;

	logic clk;
	logic arst_n;

	dhb_eval_if   eval_bus ();
	dhb_result_if result_bus ();

	deadband_heartbeat_publish_decision_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.eval_ch   (eval_bus),
		.result_ch (result_bus)
	);

	// Predictor copy of the per-point table.
	logic              published_flag [POINT_COUNT];
	logic [VALUE_W-1:0] sent_value    [POINT_COUNT];
	logic [TICK_W-1:0]  sent_tick     [POINT_COUNT];

	// Decisions predicted at acceptance, oldest first.
	result_t pending_decisions [$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int mismatches;
	int beats_accepted;
	int decisions_checked;
	int publish_count;
	int clear_count;

	// Running millisecond clock used to shape well-formed traffic.
	logic [TICK_W-1:0] wall_ms;

	result_t want;
	result_t got;

	always #5 clk = ~clk;

	// Work out the decision for one accepted beat and update the table copy.
	function automatic result_t decide_publish(input eval_item_t beat);
		result_t            r;
		logic signed [32:0] delta;
		logic [32:0]        magnitude;
		logic [TICK_W-1:0]  elapsed;
		logic               due;
		point_idx_t         idx;
		r = '0;
		idx = beat.point_index;
		if (beat.operation == OP_CLEAR) begin
			// Drop every flag; stored values and ticks stay.
			for (int i = 0; i < POINT_COUNT; i++)
				published_flag[i] = 1'b0;
			return r;
		end
		if (!published_flag[idx]) begin
			due = 1'b1;
		end else if (beat.is_text) begin
			due = (beat.sample_value != sent_value[idx]);
		end else if (beat.deadband == '0) begin
			due = 1'b1;
		end else begin
			// Sign-extend both sides to 33 bits so the change never overflows.
			delta = {beat.sample_value[VALUE_W-1], beat.sample_value}
				- {sent_value[idx][VALUE_W-1], sent_value[idx]};
			magnitude = delta[32] ? 33'(-delta) : 33'(delta);
			due = (magnitude >= 33'(beat.deadband));
		end
		if (!due && published_flag[idx] && beat.heartbeat_seconds != '0) begin
			// Elapsed time wraps modulo two to the 32.
			elapsed = beat.now_ms - sent_tick[idx];
			due = (elapsed >= 32'(beat.heartbeat_seconds) * 32'(MS_PER_SECOND));
		end
		if (due) begin
			published_flag[idx] = 1'b1;
			sent_value[idx] = beat.sample_value;
			sent_tick[idx] = beat.now_ms;
			r.publish = 1'b1;
			r.published_value = beat.sample_value;
		end
		return r;
	endfunction

	function automatic eval_item_t make_beat(input op_t op, input point_idx_t idx,
		input logic [VALUE_W-1:0] value, input logic text, input logic [BAND_W-1:0] band,
		input logic [HB_W-1:0] hb, input logic [TICK_W-1:0] now);
		eval_item_t b;
		b.operation = op;
		b.point_index = idx;
		b.sample_value = value;
		b.is_text = text;
		b.deadband = band;
		b.heartbeat_seconds = hb;
		b.now_ms = now;
		return b;
	endfunction

	// Compare results against the oldest prediction, then record any beat accepted
	// at this edge. A result can never belong to a beat taken on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				got = result_bus.data;
				if (pending_decisions.size() == 0) begin
					$display("%0t: result with nothing pending: publish=%0b value=%0d",
						$time, got.publish, got.published_value);
					mismatches++;
				end else begin
					want = pending_decisions.pop_front();
					decisions_checked++;
					if (got.publish !== want.publish) begin
						$display("%0t: publish mismatch: expected %0b actual %0b",
							$time, want.publish, got.publish);
						mismatches++;
					end
					if (got.published_value !== want.published_value) begin
						$display("%0t: published_value mismatch: expected %0d actual %0d",
							$time, want.published_value, got.published_value);
						mismatches++;
					end
					if (want.publish)
						publish_count++;
				end
			end
			if (eval_bus.valid && eval_bus.ready) begin
				if (eval_bus.data.operation == OP_CLEAR)
					clear_count++;
				pending_decisions.push_back(decide_publish(eval_bus.data));
				beats_accepted++;
			end
		end
	end

	// Receiver: stall at random, changing ready only on the falling edge.
	always @(negedge clk) begin
		result_bus.ready = ($urandom_range(99) >= receiver_stall_pct);
	end

	// Send one beat: idle first at random, then hold valid until accepted.
	// Returns at the falling edge after acceptance with valid still high.
	task automatic send_beat(input eval_item_t beat);
		while ($urandom_range(99) < sender_idle_pct) begin
			eval_bus.valid = 1'b0;
			@(negedge clk);
		end
		eval_bus.valid = 1'b1;
		eval_bus.data = beat;
		do
			@(posedge clk);
		while (!eval_bus.ready);
		@(negedge clk);
	endtask

	// Extremes of every field, each decision path, clear, and back-to-back
	// beats on one index so write-back forwarding is exercised.
	task automatic test_directed_cases();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		// First value, then below, at, and with no deadband.
		send_beat(make_beat(OP_EVALUATE, 8'd0, 32'd100, 1'b0, 16'd10, 16'd0, 32'd1000));
		send_beat(make_beat(OP_EVALUATE, 8'd0, 32'd109, 1'b0, 16'd10, 16'd0, 32'd1001));
		send_beat(make_beat(OP_EVALUATE, 8'd0, 32'd110, 1'b0, 16'd10, 16'd0, 32'd1002));
		send_beat(make_beat(OP_EVALUATE, 8'd0, 32'd110, 1'b0, 16'd0, 16'd0, 32'd1003));
		// Full-scale swing needs the 33-bit difference.
		send_beat(make_beat(OP_EVALUATE, 8'd1, 32'h7FFF_FFFF, 1'b0, 16'hFFFF, 16'd0, 32'd0));
		send_beat(make_beat(OP_EVALUATE, 8'd1, 32'h8000_0000, 1'b0, 16'hFFFF, 16'd0, 32'd0));
		send_beat(make_beat(OP_EVALUATE, 8'd1, 32'h8000_FFFE, 1'b0, 16'hFFFF, 16'd0, 32'd0));
		// Text: same checksum holds even with no deadband, any change publishes.
		send_beat(make_beat(OP_EVALUATE, 8'd2, 32'hDEAD_BEEF, 1'b1, 16'd0, 16'd0, 32'd5000));
		send_beat(make_beat(OP_EVALUATE, 8'd2, 32'hDEAD_BEEF, 1'b1, 16'd0, 16'd0, 32'd5001));
		send_beat(make_beat(OP_EVALUATE, 8'd2, 32'hDEAD_BEEE, 1'b1, 16'hFFFF, 16'd0, 32'd5002));
		// Heartbeat across the tick wrap: one ms short, then exactly due.
		send_beat(make_beat(OP_EVALUATE, 8'd3, 32'd0, 1'b0, 16'd100, 16'd2, 32'hFFFF_FC18));
		send_beat(make_beat(OP_EVALUATE, 8'd3, 32'd0, 1'b0, 16'd100, 16'd2, 32'h0000_03E7));
		send_beat(make_beat(OP_EVALUATE, 8'd3, 32'd0, 1'b0, 16'd100, 16'd2, 32'h0000_03E8));
		send_beat(make_beat(OP_EVALUATE, 8'd3, 32'd0, 1'b0, 16'd100, 16'd0, 32'hFFFF_FFFF));
		// Longest heartbeat period: due at the bound, not one ms before it.
		send_beat(make_beat(OP_EVALUATE, 8'd4, -32'sd5, 1'b0, 16'd1, 16'hFFFF, 32'd0));
		send_beat(make_beat(OP_EVALUATE, 8'd4, -32'sd5, 1'b0, 16'd1, 16'hFFFF, 32'd65535000));
		send_beat(make_beat(OP_EVALUATE, 8'd4, -32'sd5, 1'b0, 16'd1, 16'hFFFF,
			32'd65535000 + 32'd65534999));
		// Clear forces a republish of a value that would otherwise hold.
		send_beat(make_beat(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF));
		send_beat(make_beat(OP_EVALUATE, 8'd0, 32'd110, 1'b0, 16'hFFFF, 16'd0, 32'd2000));
		send_beat(make_beat(OP_EVALUATE, 8'd0, 32'd110, 1'b0, 16'hFFFF, 16'd0, 32'd2001));
		// Top index, text and numeric mixed on the same slot.
		send_beat(make_beat(OP_EVALUATE, 8'hFF, 32'h8000_0000, 1'b0, 16'd7, 16'd1, 32'd10));
		send_beat(make_beat(OP_EVALUATE, 8'hFF, 32'h7FFF_FFFF, 1'b1, 16'd7, 16'd1, 32'd11));
		send_beat(make_beat(OP_EVALUATE, 8'hFF, 32'h7FFF_FFFF, 1'b1, 16'd7, 16'hFFFF, 32'd12));
	endtask

	// Mostly plausible traffic on a few points so deadband and heartbeat
	// both matter, with some clears and fully random noise beats mixed in.
	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		eval_item_t         beat;
		logic [127:0]       noise_bits;
		int unsigned        pick;
		int                 band_offset;
		logic [VALUE_W-1:0] step;
		point_idx_t         idx;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			noise_bits = {$urandom, $urandom, $urandom, $urandom};
			beat = eval_item_t'(noise_bits[$bits(eval_item_t)-1:0]);
			pick = $urandom_range(99);
			if (pick < 2) begin
				beat.operation = OP_CLEAR;
			end else if (pick < 17) begin
				beat.operation = OP_EVALUATE;
			end else begin
				beat.operation = OP_EVALUATE;
				idx = ($urandom_range(9) < 7) ? point_idx_t'($urandom_range(7))
					: point_idx_t'($urandom);
				beat.point_index = idx;
				// Advance time; jump far now and then so the tick wraps.
				if ($urandom_range(99) == 0)
					wall_ms = wall_ms + $urandom;
				else
					wall_ms = wall_ms + $urandom_range(3000);
				beat.now_ms = wall_ms;
				case ($urandom_range(3))
					0: beat.heartbeat_seconds = '0;
					1: beat.heartbeat_seconds = HB_W'($urandom_range(1, 3));
					2: beat.heartbeat_seconds = HB_W'($urandom_range(4, 20));
					default: beat.heartbeat_seconds = HB_W'($urandom);
				endcase
				case ($urandom_range(3))
					0: beat.deadband = '0;
					1: beat.deadband = BAND_W'($urandom_range(1, 16));
					2: beat.deadband = BAND_W'($urandom_range(100, 5000));
					default: beat.deadband = BAND_W'($urandom);
				endcase
				beat.is_text = ($urandom_range(4) == 0);
				if (!published_flag[idx]) begin
					beat.sample_value = $urandom;
				end else if (beat.is_text) begin
					// Repeat the checksum half the time, else flip one bit.
					beat.sample_value = sent_value[idx];
					if ($urandom_range(1))
						beat.sample_value[$urandom_range(VALUE_W-1)] ^= 1'b1;
				end else if ($urandom_range(9) == 0) begin
					beat.sample_value = $urandom;
				end else begin
					// Land just below, at, or just above the deadband.
					band_offset = int'(beat.deadband) + $urandom_range(2) - 1;
					if (band_offset < 0)
						band_offset = 0;
					step = VALUE_W'(band_offset);
					beat.sample_value = $urandom_range(1) ? sent_value[idx] + step
						: sent_value[idx] - step;
				end
			end
			send_beat(beat);
		end
	endtask

	// Hold the sender until every pending decision has arrived, then resume.
	task automatic test_hold_until_drained();
		eval_bus.valid = 1'b0;
		while (pending_decisions.size() != 0)
			@(negedge clk);
		@(negedge clk);
		send_beat(make_beat(OP_EVALUATE, 8'd5, 32'd42, 1'b0, 16'd0, 16'd0, wall_ms));
		send_beat(make_beat(OP_EVALUATE, 8'd5, 32'd42, 1'b0, 16'd1, 16'd0, wall_ms));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		eval_bus.valid = 1'b0;
		eval_bus.data = '0;
		result_bus.ready = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		mismatches = 0;
		beats_accepted = 0;
		decisions_checked = 0;
		publish_count = 0;
		clear_count = 0;
		wall_ms = $urandom;
		for (int i = 0; i < POINT_COUNT; i++)
			published_flag[i] = 1'b0;

		// Single reset at the start; release on a falling edge.
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_random_traffic(PHASE_BEATS, 0, 0);
		test_hold_until_drained();
		test_random_traffic(PHASE_BEATS, 67, 0);
		test_random_traffic(PHASE_BEATS, 0, 67);
		test_hold_until_drained();
		test_random_traffic(PHASE_BEATS, 33, 33);

		// Drain, then allow a few more cycles for any stray result.
		eval_bus.valid = 1'b0;
		while (pending_decisions.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d beats (%0d clears); checked %0d decisions, %0d of them publishes,",
			beats_accepted, clear_count, decisions_checked, publish_count);
		$display("over directed cases and four idle/stall phases with drain pauses.");
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d decisions still pending", pending_decisions.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[deadband_heartbeat_publish_decision_unit.f]
hdl/dhb_pkg.sv
hdl/dhb_eval_if.sv
hdl/dhb_result_if.sv
hdl/dhb_slot_mem.sv
hdl/dhb_decide.sv
hdl/deadband_heartbeat_publish_decision_unit.sv
tb/sv/deadband_heartbeat_publish_decision_unit_tb.sv
